// ===== hw/rtl/dlx_pkg.sv =====
// ----------------------------------------------------------------------------
// dlx_pkg - shared types and constants of the decimal number lexer
// token codes, lexer phases, character classes and the view of one result
// ----------------------------------------------------------------------------
package dlx_pkg;

  typedef enum logic [3:0] {
    TK_NUM    = 4'd0,
    TK_ADD    = 4'd1,
    TK_SUB    = 4'd2,
    TK_MUL    = 4'd3,
    TK_DIV    = 4'd4,
    TK_LPAREN = 4'd5,
    TK_RPAREN = 4'd6,
    TK_END    = 4'd7,
    TK_ERROR  = 4'd8
  } tok_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INT  = 2'd1,
    PH_DOT  = 2'd2,
    PH_FRAC = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    CC_DIGIT,
    CC_DOT,
    CC_MINUS,
    CC_PLUS,
    CC_STAR,
    CC_SLASH,
    CC_LPAR,
    CC_RPAR,
    CC_EQ,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } char_info_t;

  // everything of a result except the mantissa
  typedef struct packed {
    tok_kind_t  tok;
    phase_t     phase;
    logic       neg;
    logic [3:0] frac;
    logic       ovf;
  } lex_view_t;

  localparam int unsigned MANT_OUT_BITS = 32;
  localparam logic [3:0]  FRAC_MAX      = 4'd15;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_EQ    = 8'h3D;

endpackage

// ===== hw/rtl/dlx_classify.sv =====
// ----------------------------------------------------------------------------
// dlx_classify - key character classifier
// maps an ascii code to its character class and digit value
// ----------------------------------------------------------------------------
module dlx_classify (
  input  logic [7:0]          char_code,
  output dlx_pkg::char_info_t info
);
  import dlx_pkg::*;

  logic [3:0] offset;

  assign offset = 4'(char_code - CH_0);

  always_comb begin
    info.digit = offset;
    if (char_code >= CH_0 && char_code <= CH_9) begin
      info.cls = CC_DIGIT;
    end else begin
      unique case (char_code)
        CH_DOT:   info.cls = CC_DOT;
        CH_MINUS: info.cls = CC_MINUS;
        CH_PLUS:  info.cls = CC_PLUS;
        CH_STAR:  info.cls = CC_STAR;
        CH_SLASH: info.cls = CC_SLASH;
        CH_LPAR:  info.cls = CC_LPAR;
        CH_RPAR:  info.cls = CC_RPAR;
        CH_EQ:    info.cls = CC_EQ;
        default:  info.cls = CC_OTHER;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dlx_core.sv =====
// ----------------------------------------------------------------------------
// dlx_core - lexer state machine and number accumulator
// holds phase, mantissa, fraction count, sign and overflow; one step per item
// ----------------------------------------------------------------------------
module dlx_core #(
  parameter int unsigned MANTISSA_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                mode,
  input  dlx_pkg::char_info_t info,
  output dlx_pkg::lex_view_t  view_nxt,
  output logic [31:0]         mant_nxt
);
  import dlx_pkg::*;

  localparam int unsigned MB = MANTISSA_BITS;

  phase_t        phase_r, phase_nxt;
  logic [MB-1:0] acc_r, acc_nxt;
  logic [3:0]    frac_r, frac_nxt;
  logic          neg_r, neg_nxt;
  logic          ovf_r, ovf_nxt;
  tok_kind_t     tok;

  logic [MB+3:0] acc_ext;
  logic [MB+3:0] prod;
  logic          fits;

  // acc*10 + digit, taken only when it stays within the mantissa width
  assign acc_ext = {4'b0000, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{MB{1'b0}}, info.digit};
  assign fits    = (prod[MB+3:MB] == 4'b0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      frac_r  <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    tok       = TK_NUM;
    if (mode) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      frac_nxt  = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end else begin
      unique case (info.cls)
        CC_DIGIT: begin
          unique case (phase_r)
            PH_IDLE: begin
              acc_nxt   = MB'(info.digit);
              frac_nxt  = '0;
              neg_nxt   = 1'b0;
              ovf_nxt   = 1'b0;
              phase_nxt = PH_INT;
            end
            PH_INT: begin
              if (fits) acc_nxt = prod[MB-1:0];
              else      ovf_nxt = 1'b1;
            end
            PH_DOT, PH_FRAC: begin
              if (frac_r == FRAC_MAX) begin
                ovf_nxt = 1'b1;
              end else if (fits) begin
                acc_nxt  = prod[MB-1:0];
                frac_nxt = frac_r + 4'd1;
              end else begin
                ovf_nxt = 1'b1;
              end
              phase_nxt = PH_FRAC;
            end
          endcase
        end
        CC_DOT: begin
          if (phase_r == PH_IDLE) begin
            acc_nxt   = '0;
            frac_nxt  = '0;
            neg_nxt   = 1'b0;
            ovf_nxt   = 1'b0;
            phase_nxt = PH_DOT;
          end else if (phase_r == PH_INT) begin
            frac_nxt  = '0;
            phase_nxt = PH_DOT;
          end
        end
        CC_MINUS: begin
          if (phase_r == PH_IDLE) begin
            acc_nxt   = '0;
            frac_nxt  = '0;
            neg_nxt   = 1'b1;
            ovf_nxt   = 1'b0;
            phase_nxt = PH_INT;
          end else begin
            tok       = TK_SUB;
            phase_nxt = PH_IDLE;
          end
        end
        CC_PLUS:  begin tok = TK_ADD;    phase_nxt = PH_IDLE; end
        CC_STAR:  begin tok = TK_MUL;    phase_nxt = PH_IDLE; end
        CC_SLASH: begin tok = TK_DIV;    phase_nxt = PH_IDLE; end
        CC_LPAR:  begin tok = TK_LPAREN; phase_nxt = PH_IDLE; end
        CC_RPAR:  begin tok = TK_RPAREN; phase_nxt = PH_IDLE; end
        CC_EQ:    begin tok = TK_END;    phase_nxt = PH_IDLE; end
        default:  tok = TK_ERROR;
      endcase
    end
  end

  assign view_nxt.tok   = tok;
  assign view_nxt.phase = phase_nxt;
  assign view_nxt.neg   = neg_nxt;
  assign view_nxt.frac  = frac_nxt;
  assign view_nxt.ovf   = ovf_nxt;

  // low 32 bits of the accumulator, zero filled when it is narrower
  generate
    if (MB >= MANT_OUT_BITS) begin : g_mant_cut
      assign mant_nxt = acc_nxt[MANT_OUT_BITS-1:0];
    end else begin : g_mant_pad
      assign mant_nxt = {{(MANT_OUT_BITS - MB){1'b0}}, acc_nxt};
    end
  endgenerate

endmodule

// ===== hw/rtl/decimal_number_lexer.sv =====
// ----------------------------------------------------------------------------
// decimal_number_lexer - calculator keypad number tokenizer
// classifies key characters and assembles a signed exact decimal number
// ----------------------------------------------------------------------------
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------
//  in_     | in  | tuser: mode (1 = clear all); tdata: char_code
//  out_    | out | tuser: token_kind; tdata: phase, sign, mantissa,
//          |     |        fraction digits, overflow flag
//
// one result word per input word; one word per cycle while out_tready is high
// a word passes the input register, then classify and lexer step into the
// result register; the lexer state advances as the word moves across
// rst_n is synchronous, active low, clears the valids and the lexer state
// out_tready low holds the result register; the input register still takes
// one word, then in_tready drops until the result is taken
//
module decimal_number_lexer #(
  parameter int unsigned MANTISSA_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] lexer_phase, [2] is_negative,
                                  // [34:3] mantissa, [38:35] fraction_digits,
                                  // [39] overflowed
  output logic [3:0]  out_tuser   // [3:0] token_kind
);
  import dlx_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] char_r;
  logic       mode_r;

  // result register
  logic        out_valid_r;
  lex_view_t   view_r;
  logic [31:0] mant_r;

  logic        advance;
  char_info_t  info;
  lex_view_t   view_nxt;
  logic [31:0] mant_nxt;

  // the word in the input register moves on when the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      mode_r <= in_tuser;
    end
  end

  dlx_classify u_classify (
    .char_code (char_r),
    .info      (info)
  );

  dlx_core #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .mode     (mode_r),
    .info     (info),
    .view_nxt (view_nxt),
    .mant_nxt (mant_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // snapshot of the state after the word, plus its token
  always_ff @(posedge clk) begin
    if (advance) begin
      view_r <= view_nxt;
      mant_r <= mant_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = view_r.tok;
  assign out_tdata  = {view_r.ovf, view_r.frac, mant_r, view_r.neg, view_r.phase};

  // a word waiting in the input register reaches the output when not stalled
  a_moves_on : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_tready) |=> out_valid_r)
    else $error("input word did not reach the result register");

  // every operator token closes the number
  a_op_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && view_r.tok != TK_NUM && view_r.tok != TK_ERROR)
      |-> (view_r.phase == PH_IDLE))
    else $error("operator token left a number open");

  // integer and just-after-dot phases never carry fraction digits
  a_frac_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (view_r.phase == PH_INT || view_r.phase == PH_DOT))
      |-> (view_r.frac == 4'd0))
    else $error("fraction count set outside fraction phase");

  // an unknown key changes nothing, checked here on the lexer phase
  a_err_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && view_nxt.tok == TK_ERROR) |=> (view_r.phase == $past(u_core.phase_r)))
    else $error("error token changed the lexer phase");

endmodule

// ===== tb/tb_decimal_number_lexer.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_number_lexer - self-checking bench for the keypad number lexer
// drives key words and clear commands into the lexer, predicts every result
// word in step with the accepted input and compares it field by field;
// a directed key sequence comes first, then random keypad sessions with
// random gaps, stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_decimal_number_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import dlx_pkg::*;

  localparam int unsigned MANT_BITS = 32;
  // largest mantissa the accumulator may hold
  localparam logic [63:0] MANT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - MANT_BITS);
  localparam int RANDOM_WORDS   = 1000;
  localparam int HOLD_CYCLES    = 40;    // long output hold-off, fills the pipe
  localparam int HOLD_AT_WORD   = 150;
  localparam int CALM_FIRST     = 500;   // window of words with no gaps or stalls
  localparam int CALM_LAST      = 700;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 6;     // margin after the last result word
  localparam int MAX_PRINTS     = 40;

  // one result word as the bench sees it
  typedef struct packed {
    tok_kind_t   tok;
    phase_t      ph;
    logic        neg;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic        ovf;
  } lex_token_t;

  // one line of the directed key sequence
  typedef struct {
    logic       clear;
    logic [7:0] key;
    logic       known;  // result typed in below instead of predicted
    lex_token_t want;
  } key_row_t;

  localparam lex_token_t RESET_VIEW = '{tok: TK_NUM, ph: PH_IDLE, neg: 1'b0,
                                        mant: 32'd0, frac: 4'd0, ovf: 1'b0};
  localparam lex_token_t ERROR_VIEW = '{tok: TK_ERROR, ph: PH_IDLE, neg: 1'b0,
                                        mant: 32'd0, frac: 4'd0, ovf: 1'b0};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_code
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [1:0] lexer_phase, [2] is_negative, [34:3] mantissa,
                           // [38:35] fraction_digits, [39] overflowed
  logic [3:0]  out_tuser;  // [3:0] token_kind

  decimal_number_lexer #(
    .MANTISSA_BITS(MANT_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // results still owed by the lexer, oldest first
  lex_token_t pending_tokens[$];
  key_row_t   key_rows[$];

  int keys_sent    = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;  // no gaps and no stalls while set
  bit hold_done    = 1'b0;

  // lexer state as the bench tracks it
  phase_t      lx_phase;
  logic [63:0] lx_mant;
  logic [3:0]  lx_frac;
  logic        lx_neg;
  logic        lx_ovf;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // lexer prediction
  // ---------------------------------------------------------------------------

  function automatic void lex_clear();
    lx_phase = PH_IDLE;
    lx_mant  = 64'd0;
    lx_frac  = 4'd0;
    lx_neg   = 1'b0;
    lx_ovf   = 1'b0;
  endfunction

  // a new number drops the old sign, fraction count and overflow flag
  function automatic void lex_start(logic [3:0] first, logic neg);
    lx_mant = 64'(first);
    lx_frac = 4'd0;
    lx_neg  = neg;
    lx_ovf  = 1'b0;
  endfunction

  // append one decimal digit; a digit that would overflow is dropped
  function automatic logic lex_append(logic [3:0] d);
    if (lx_mant > (MANT_LIMIT - 64'(d)) / 64'd10) begin
      lx_ovf = 1'b1;
      return 1'b0;
    end
    lx_mant = lx_mant * 64'd10 + 64'(d);
    return 1'b1;
  endfunction

  // advance the tracked lexer by one key word and return the result word
  function automatic lex_token_t tokenize_key(logic clear, logic [7:0] key);
    tok_kind_t tok;
    tok = TK_NUM;
    if (clear) begin
      lex_clear();
    end else if (key >= CH_0 && key <= CH_9) begin
      // ascii digits keep their value in the low nibble
      case (lx_phase)
        PH_IDLE: begin
          lex_start(key[3:0], 1'b0);
          lx_phase = PH_INT;
        end
        PH_INT: void'(lex_append(key[3:0]));
        default: begin
          // fraction digit: dropped once the count is full
          if (lx_frac >= FRAC_MAX) lx_ovf = 1'b1;
          else if (lex_append(key[3:0])) lx_frac = lx_frac + 4'd1;
          lx_phase = PH_FRAC;
        end
      endcase
    end else if (key == CH_DOT) begin
      // a second dot inside a number is ignored
      if (lx_phase == PH_IDLE) begin
        lex_start(4'd0, 1'b0);
        lx_phase = PH_DOT;
      end else if (lx_phase == PH_INT) begin
        lx_frac  = 4'd0;
        lx_phase = PH_DOT;
      end
    end else if (key == CH_MINUS && lx_phase == PH_IDLE) begin
      // leading minus opens a negative number
      lex_start(4'd0, 1'b1);
      lx_phase = PH_INT;
    end else begin
      case (key)
        CH_MINUS: tok = TK_SUB;
        CH_PLUS:  tok = TK_ADD;
        CH_STAR:  tok = TK_MUL;
        CH_SLASH: tok = TK_DIV;
        CH_LPAR:  tok = TK_LPAREN;
        CH_RPAR:  tok = TK_RPAREN;
        CH_EQ:    tok = TK_END;
        default:  tok = TK_ERROR;
      endcase
      // operators end the number but leave it visible, junk changes nothing
      if (tok != TK_ERROR) lx_phase = PH_IDLE;
    end
    return '{tok: tok, ph: lx_phase, neg: lx_neg, mant: lx_mant[31:0],
             frac: lx_frac, ovf: lx_ovf};
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic clear, logic [7:0] key, logic known = 1'b0,
                                  lex_token_t want = '0);
    key_row_t r;
    r.clear = clear;
    r.key   = key;
    r.known = known;
    r.want  = want;
    key_rows.push_back(r);
  endfunction

  // offer one word from a falling edge and return at the falling edge after
  // it is taken; the prediction is made in acceptance order
  task automatic send_key(input logic clear, input logic [7:0] key,
                          input logic known = 1'b0, input lex_token_t want = '0);
    lex_token_t next;
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= clear;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    next = tokenize_key(clear, key);
    pending_tokens.push_back(known ? want : next);
    keys_sent++;
    @(negedge clk);
  endtask

  // random digit key
  function automatic logic [7:0] any_digit();
    return 8'(CH_0 + $urandom_range(9));
  endfunction

  initial begin : stimulus
    string      digits;
    logic [7:0] op_keys [7];
    int         n;
    int         pick;

    op_keys = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR, CH_EQ};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = 8'h00;
    lex_clear();

    // directed sequence
    add_row(1'b1, 8'hFF, 1'b1, RESET_VIEW);  // clear, the char code is ignored
    add_row(1'b0, 8'hFF, 1'b1, ERROR_VIEW);  // top code is junk
    add_row(1'b0, 8'h00, 1'b1, ERROR_VIEW);  // bottom code is junk
    add_row(1'b0, CH_DOT);                    // dot opens a number
    add_row(1'b0, CH_DOT);                    // second dot ignored right after the dot
    add_row(1'b0, CH_9);                      // first fraction digit
    add_row(1'b0, CH_DOT);                    // dot ignored inside the fraction
    add_row(1'b0, CH_PLUS);
    add_row(1'b0, CH_MINUS);                  // leading minus: negative number
    add_row(1'b0, CH_MINUS);                  // minus inside a number: subtraction
    add_row(1'b0, CH_MINUS);                  // negative again
    digits = "4294967295";                    // largest 32-bit mantissa
    for (int i = 0; i < digits.len(); i++) add_row(1'b0, digits[i]);
    // one more digit overflows, even a zero
    add_row(1'b0, CH_0, 1'b1, '{tok: TK_NUM, ph: PH_INT, neg: 1'b1,
                                mant: 32'hFFFF_FFFF, frac: 4'd0, ovf: 1'b1});
    add_row(1'b0, CH_DOT);
    add_row(1'b0, CH_9);                      // fraction digit dropped on overflow
    add_row(1'b0, CH_STAR);
    add_row(1'b0, CH_SLASH);
    add_row(1'b0, CH_LPAR);
    add_row(1'b0, CH_RPAR);
    add_row(1'b0, CH_EQ);
    add_row(1'b0, 8'h41);                     // letter key: error, state kept
    add_row(1'b0, 8'h80);                     // upper half code: error

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (key_rows[i]) begin
      send_key(key_rows[i].clear, key_rows[i].key, key_rows[i].known, key_rows[i].want);
    end

    // random keypad sessions
    while (keys_sent < key_rows.size() + RANDOM_WORDS) begin
      calm = (keys_sent >= CALM_FIRST && keys_sent < CALM_LAST);
      pick = $urandom_range(99);
      if (pick < 60) begin
        // well formed number, mostly short, sometimes long enough to overflow
        if ($urandom_range(2) == 0) send_key(1'b0, CH_MINUS);
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n) send_key(1'b0, any_digit());
        if ($urandom_range(1) == 1) begin
          send_key(1'b0, CH_DOT);
          n = ($urandom_range(7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
          repeat (n) send_key(1'b0, any_digit());
        end
        send_key(1'b0, op_keys[$urandom_range(6)]);
      end else if (pick < 70) begin
        // long zero fraction: runs the fraction count close to or up to its limit
        send_key(1'b0, CH_DOT);
        repeat ($urandom_range(13, 17)) send_key(1'b0, CH_0);
        repeat ($urandom_range(1, 3)) send_key(1'b0, any_digit());
        send_key(1'b0, op_keys[$urandom_range(6)]);
      end else if (pick < 78) begin
        send_key(1'b1, 8'($urandom_range(255)));  // clear with junk char code
      end else if (pick < 90) begin
        send_key(1'b0, 8'($urandom_range(255)));  // any code at all
      end else begin
        // stray keypad keys in any phase
        case ($urandom_range(2))
          0:       send_key(1'b0, CH_DOT);
          1:       send_key(1'b0, any_digit());
          default: send_key(1'b0, op_keys[$urandom_range(6)]);
        endcase
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // random stalls, plus one long hold-off so the lexer backs up into its input
  initial begin : result_sink
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && keys_sent >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= !(!calm && $urandom_range(99) < 9);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: result word %0d, %s: got %0h, want %0h",
               $realtime, results_seen, what, got, want);
    end
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    lex_token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(out_tuser), 32'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (out_tuser !== want.tok)
          report_mismatch("token_kind", 32'(out_tuser), 32'(want.tok));
        if (out_tdata[1:0] !== want.ph)
          report_mismatch("lexer_phase", 32'(out_tdata[1:0]), 32'(want.ph));
        if (out_tdata[2] !== want.neg)
          report_mismatch("is_negative", 32'(out_tdata[2]), 32'(want.neg));
        if (out_tdata[34:3] !== want.mant)
          report_mismatch("mantissa", out_tdata[34:3], want.mant);
        if (out_tdata[38:35] !== want.frac)
          report_mismatch("fraction_digits", 32'(out_tdata[38:35]), 32'(want.frac));
        if (out_tdata[39] !== want.ovf)
          report_mismatch("overflowed", 32'(out_tdata[39]), 32'(want.ovf));
      end
      results_seen++;
    end
  end

  // watchdog: ends a run in which no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
